[hw/rtl/sfp_pkg.sv]
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int HEADER_LEN       = 8;
  localparam int NUMBER_POS       = 3;
  localparam int NUMBER_CHECK_POS = 4;
  localparam int LENGTH_POS       = 5;
  localparam int MAX_FRAME        = 2048;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_SYNC1   = 3'd0;
  localparam logic [PH_W-1:0] PH_SYNC2   = 3'd1;
  localparam logic [PH_W-1:0] PH_SYNC3   = 3'd2;
  localparam logic [PH_W-1:0] PH_HEADER  = 3'd3;
  localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PH_W-1:0] PH_CRC     = 3'd5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_MASK    = 2'd3;

  localparam logic [1:0] CHK_LOW  = 2'd2;
  localparam logic [1:0] CHK_HIGH = 2'd1;
  localparam logic [1:0] CHK_NONE = 2'd0;

endpackage

[hw/rtl/sync_frame_parser_crc16.sv]
// a result word appears on out_valid in the cycle after its input word is taken
// throughput: one word per cycle while in_stall is low; the phase step and a byte-wide crc update share one stage
// in_stall is high only while a result waits in the output register and out_stall is high
// synchronous active-low reset clears the phase, byte count, check count and output valid,
// and sets the sync bytes to 0 and the number mask to 0xff
`timescale 1ns / 1ps

module sync_frame_parser_crc16 (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_payload_valid,
  output logic [7:0]                     out_payload_byte,
  output logic                           out_frame_good,
  output logic                           out_frame_crc_error,
  output logic                           out_header_error,
  output logic                           out_overflow_drop,
  output logic [7:0]                     out_frame_number,
  output logic [15:0]                    out_payload_length,
  output logic [15:0]                    out_computed_crc
);

  localparam int CW = sfp_pkg::CNT_W;

  logic [7:0] sync_first_r, sync_second_r, sync_third_r, xor_mask_r;

  logic [sfp_pkg::PH_W-1:0] phase_r, phase_nxt;
  logic [CW-1:0]            byte_count_r, byte_count_nxt;
  logic [7:0]               number_r, number_nxt;
  logic [7:0]               check_r, check_nxt;
  logic [7:0]               len_lo_r, len_lo_nxt;
  logic [7:0]               len_hi_r, len_hi_nxt;
  logic [15:0]              length_r, length_nxt;
  logic [15:0]              remaining_r, remaining_nxt;
  logic [1:0]               check_count_r, check_count_nxt;
  logic [15:0]              crc_r, crc_nxt;
  logic [7:0]               crc_low_r, crc_low_nxt;

  logic [15:0] crc_upd;
  logic [15:0] rem_dec;
  logic [CW-1:0] cnt_inc;
  logic        in_accept;

  logic        pv, good, bad, herr, ovf, show_hdr, ended;
  logic [7:0]  pb;
  logic [15:0] ccrc;

  logic        out_valid_r;
  logic        pv_r, good_r, bad_r, herr_r, ovf_r;
  logic [7:0]  pb_r, fnum_r;
  logic [15:0] plen_r, ccrc_r;

  sfp_crc_byte u_crc (
    .crc_in  (crc_r),
    .data    (in_data_byte),
    .crc_out (crc_upd)
  );

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cnt_inc   = byte_count_r + CW'(1);
  assign rem_dec   = remaining_r - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'h00;
      sync_second_r <= 8'h00;
      sync_third_r  <= 8'h00;
      xor_mask_r    <= 8'hff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        sfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        sfp_pkg::CFG_SYNC_THIRD:  sync_third_r  <= cfg_data;
        sfp_pkg::CFG_XOR_MASK:    xor_mask_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] len_hdr;
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    number_nxt      = number_r;
    check_nxt       = check_r;
    len_lo_nxt      = len_lo_r;
    len_hi_nxt      = len_hi_r;
    length_nxt      = length_r;
    remaining_nxt   = remaining_r;
    check_count_nxt = check_count_r;
    crc_nxt         = crc_r;
    crc_low_nxt     = crc_low_r;
    pv       = 1'b0;
    pb       = 8'h00;
    good     = 1'b0;
    bad      = 1'b0;
    herr     = 1'b0;
    ovf      = 1'b0;
    show_hdr = 1'b0;
    ended    = 1'b0;
    ccrc     = 16'h0000;
    len_hdr  = 16'h0000;

    unique case (phase_r) inside
      sfp_pkg::PH_SYNC2, sfp_pkg::PH_SYNC3: begin
        if (in_data_byte == ((phase_r == sfp_pkg::PH_SYNC2) ? sync_second_r : sync_third_r)) begin
          byte_count_nxt = cnt_inc;
          phase_nxt = (phase_r == sfp_pkg::PH_SYNC2) ? sfp_pkg::PH_SYNC3 : sfp_pkg::PH_HEADER;
        end else begin
          phase_nxt      = sfp_pkg::PH_SYNC1;
          byte_count_nxt = '0;
        end
      end
      sfp_pkg::PH_HEADER: begin
        if (byte_count_r == CW'(sfp_pkg::NUMBER_POS))       number_nxt = in_data_byte;
        if (byte_count_r == CW'(sfp_pkg::NUMBER_CHECK_POS)) check_nxt  = in_data_byte;
        if (byte_count_r == CW'(sfp_pkg::LENGTH_POS))       len_lo_nxt = in_data_byte;
        if (byte_count_r == CW'(sfp_pkg::LENGTH_POS + 1))   len_hi_nxt = in_data_byte;
        byte_count_nxt = cnt_inc;
        if (byte_count_r >= CW'(sfp_pkg::HEADER_LEN - 1)) begin
          show_hdr   = 1'b1;
          len_hdr    = {len_hi_nxt, len_lo_nxt};
          length_nxt = len_hdr;
          if (number_nxt != (check_nxt ^ xor_mask_r)) begin
            herr           = 1'b1;
            ended          = 1'b1;
            phase_nxt      = sfp_pkg::PH_SYNC1;
            byte_count_nxt = '0;
          end else begin
            remaining_nxt = len_hdr;
            crc_nxt       = 16'h0000;
            if (len_hdr == 16'h0000) begin
              check_count_nxt = sfp_pkg::CHK_LOW;
              phase_nxt       = sfp_pkg::PH_CRC;
            end else begin
              phase_nxt = sfp_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      sfp_pkg::PH_PAYLOAD: begin
        byte_count_nxt = cnt_inc;
        show_hdr       = 1'b1;
        pv             = 1'b1;
        pb             = in_data_byte;
        crc_nxt        = crc_upd;
        remaining_nxt  = rem_dec;
        if (rem_dec == 16'h0000) begin
          check_count_nxt = sfp_pkg::CHK_LOW;
          phase_nxt       = sfp_pkg::PH_CRC;
        end
      end
      sfp_pkg::PH_CRC: begin
        byte_count_nxt = cnt_inc;
        show_hdr       = 1'b1;
        if (check_count_r[1]) begin
          crc_low_nxt     = in_data_byte;
          check_count_nxt = sfp_pkg::CHK_HIGH;
        end else begin
          check_count_nxt = sfp_pkg::CHK_NONE;
          ccrc            = crc_r;
          good            = ({in_data_byte, crc_low_r} == crc_r);
          bad             = ~good;
          ended           = 1'b1;
          phase_nxt       = sfp_pkg::PH_SYNC1;
          byte_count_nxt  = '0;
        end
      end
      default: begin
        if (in_data_byte == sync_first_r) begin
          byte_count_nxt = CW'(1);
          phase_nxt      = sfp_pkg::PH_SYNC2;
        end else begin
          phase_nxt      = sfp_pkg::PH_SYNC1;
          byte_count_nxt = '0;
        end
      end
    endcase

    if (!ended && phase_nxt != sfp_pkg::PH_SYNC1 &&
        byte_count_nxt >= CW'(sfp_pkg::MAX_FRAME)) begin
      ovf            = 1'b1;
      phase_nxt      = sfp_pkg::PH_SYNC1;
      byte_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= sfp_pkg::PH_SYNC1;
      byte_count_r  <= '0;
      check_count_r <= sfp_pkg::CHK_NONE;
    end else if (in_accept) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      check_count_r <= check_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      number_r    <= number_nxt;
      check_r     <= check_nxt;
      len_lo_r    <= len_lo_nxt;
      len_hi_r    <= len_hi_nxt;
      length_r    <= length_nxt;
      remaining_r <= remaining_nxt;
      crc_r       <= crc_nxt;
      crc_low_r   <= crc_low_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pv_r   <= pv;
      pb_r   <= pb;
      good_r <= good;
      bad_r  <= bad;
      herr_r <= herr;
      ovf_r  <= ovf;
      fnum_r <= show_hdr ? number_nxt : 8'h00;
      plen_r <= show_hdr ? length_nxt : 16'h0000;
      ccrc_r <= ccrc;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_valid   = pv_r;
  assign out_payload_byte    = pb_r;
  assign out_frame_good      = good_r;
  assign out_frame_crc_error = bad_r;
  assign out_header_error    = herr_r;
  assign out_overflow_drop   = ovf_r;
  assign out_frame_number    = fnum_r;
  assign out_payload_length  = plen_r;
  assign out_computed_crc    = ccrc_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({good_r, bad_r, herr_r, ovf_r}))
    else $error("more than one frame end flag set");

  a_payload_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pv_r) |-> !(good_r || bad_r || herr_r))
    else $error("payload word flagged as frame end");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted word produced no result");

  a_hunt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (ended || ovf)) |=> (phase_r == sfp_pkg::PH_SYNC1 && byte_count_r == '0))
    else $error("parser not hunting after frame end");

  a_reset_hunt: assert property (@(posedge clk)
    $past(!rst_n) |-> (phase_r == sfp_pkg::PH_SYNC1 && !out_valid_r))
    else $error("reset did not clear parser");

endmodule

[hw/rtl/sfp_crc_byte.sv]
`timescale 1ns / 1ps

module sfp_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  // msb-first crc-16, one byte per call
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ sfp_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
